@@ design/cht_pkg.sv @@
// Shared types and constants of the capability health tracker.
`default_nettype none

package cht_pkg;

  // Command codes carried by a request
  typedef enum logic [2:0] {
    CMD_SET_OFFERED   = 3'd0,
    CMD_OBSERVE       = 3'd1,
    CMD_WITHDRAW      = 3'd2,
    CMD_TRANSPORT     = 3'd3,
    CMD_CAPTURE_LEASE = 3'd4,
    CMD_CHECK_LEASE   = 3'd5
  } cmd_e;

  // Link health states
  typedef enum logic [1:0] {
    HEALTH_UNKNOWN     = 2'd0,
    HEALTH_HEALTHY     = 2'd1,
    HEALTH_DEGRADED    = 2'd2,
    HEALTH_UNAVAILABLE = 2'd3
  } health_e;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned KNOWN_W    = 32;
  localparam int unsigned THRESH_W   = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KNOWN_MASK    = 4'd0,
    REG_SUCC_TO_OK    = 4'd1,
    REG_FAIL_TO_UNAV  = 4'd2
  } reg_idx_e;

  // Register reset values
  localparam logic [KNOWN_W-1:0]  KNOWN_MASK_RST = '1;
  localparam logic [THRESH_W-1:0] SUCC_THR_RST   = 4'd2;
  localparam logic [THRESH_W-1:0] FAIL_THR_RST   = 4'd3;

endpackage

`default_nettype wire

@@ design/cht_if.sv @@
// Request, result and configuration channel interfaces of the tracker.
`default_nettype none

interface cht_req_if #(
  parameter int unsigned FLAG_BITS = 32,
  parameter int unsigned GEN_BITS  = 32
);
  import cht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           command;
  logic [FLAG_BITS-1:0] caps_value;
  logic                 success;
  logic [GEN_BITS-1:0]  lease_generation;

  modport source (output valid, command, caps_value, success, lease_generation,
                  input ready);
  modport sink   (input valid, command, caps_value, success, lease_generation,
                  output ready);
endinterface

interface cht_rsp_if #(
  parameter int unsigned FLAG_BITS = 32,
  parameter int unsigned GEN_BITS  = 32
);
  import cht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [GEN_BITS-1:0]  generation;
  logic [1:0]           health;
  logic [FLAG_BITS-1:0] operational_caps;
  logic [FLAG_BITS-1:0] negotiated_caps;
  logic                 acceptance_seen;

  modport source (output valid, ok, generation, health, operational_caps,
                  negotiated_caps, acceptance_seen, input ready);
  modport sink   (input valid, ok, generation, health, operational_caps,
                  negotiated_caps, acceptance_seen, output ready);
endinterface

interface cht_cfg_if;
  import cht_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/capability_health_tracker_core.sv @@
// Capability health tracker: offered/accepted sets, link health and generation.
//
// Channels: req_i takes one request per handshake (command, caps_value,
// success, lease_generation). rsp_o returns exactly one result per request,
// in order: ok, generation, health, operational and negotiated sets and the
// acceptance flag, all taken after the command has been applied. cfg_i
// writes known_mask (index 0), successes_to_healthy (1) and
// failures_to_unavailable (2); other indexes are ignored, cfg_i is always
// ready, and writes belong to idle periods.
// Flow: one input register, one result register; the state update between
// them is combinational. Throughput: one request per cycle while rsp_o is
// not held off, set by the state update between the two registers.
// Stall: while rsp_o is held off, one finished result waits in the result
// register and one request waits in the input register; req_i.ready drops
// only when both are full, and nothing is lost or repeated.
// Reset: all sets and counters clear, health goes unknown, generation goes
// to one and the registers take their reset values; no request is pending.
`default_nettype none

module capability_health_tracker_core #(
  parameter int unsigned FLAG_BITS  = 32,
  parameter int unsigned GEN_BITS   = 32,
  parameter int unsigned COUNT_BITS = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cht_req_if.sink   req_i,
  cht_rsp_if.source rsp_o,
  cht_cfg_if.sink   cfg_i
);
  import cht_pkg::*;

  localparam int unsigned CmpW = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

  // Configuration registers
  logic [KNOWN_W-1:0]  known_mask_q;
  logic [THRESH_W-1:0] succ_thr_q;
  logic [THRESH_W-1:0] fail_thr_q;

  // Tracker state
  logic [FLAG_BITS-1:0]  offered_q, offered_d;
  logic [FLAG_BITS-1:0]  accepted_q, accepted_d;
  logic [FLAG_BITS-1:0]  negotiated_q, negotiated_d;
  logic [FLAG_BITS-1:0]  oper_q, oper_d;
  health_e               health_q, health_d;
  logic [COUNT_BITS-1:0] fail_cnt_q, fail_cnt_d;
  logic [COUNT_BITS-1:0] succ_cnt_q, succ_cnt_d;
  logic                  acc_q, acc_d;
  logic [GEN_BITS-1:0]   gen_q, gen_d;

  // Input register
  logic                 in_valid_q;
  logic [2:0]           cmd_q;
  logic [FLAG_BITS-1:0] caps_q;
  logic                 success_q;
  logic [GEN_BITS-1:0]  lease_q;

  // Result register
  logic                 out_valid_q;
  logic                 ok_q, ok_d;

  logic                 advance;
  logic [FLAG_BITS-1:0] known_flags;
  logic                 caps_ok;
  logic [GEN_BITS-1:0]  gen_inc;
  logic [GEN_BITS-1:0]  gen_bumped;
  logic [CmpW-1:0]      succ_thr_ext;
  logic [CmpW-1:0]      fail_thr_ext;
  logic [COUNT_BITS-1:0] succ_next;
  logic [COUNT_BITS-1:0] fail_next;

  // Widen the 32-bit known mask to the flag width; bits above it are zero
  for (genvar gi = 0; gi < FLAG_BITS; gi++) begin : g_known
    if (gi < KNOWN_W) begin : g_in
      assign known_flags[gi] = known_mask_q[gi];
    end else begin : g_out
      assign known_flags[gi] = 1'b0;
    end
  end

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_mask_q <= KNOWN_MASK_RST;
      succ_thr_q   <= SUCC_THR_RST;
      fail_thr_q   <= FAIL_THR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_KNOWN_MASK:   known_mask_q <= cfg_i.data[KNOWN_W-1:0];
        REG_SUCC_TO_OK:   succ_thr_q   <= cfg_i.data[THRESH_W-1:0];
        REG_FAIL_TO_UNAV: fail_thr_q   <= cfg_i.data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: the input stage moves on when the result register frees up
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q     <= req_i.command;
      caps_q    <= req_i.caps_value;
      success_q <= req_i.success;
      lease_q   <= req_i.lease_generation;
    end
  end

  // Shared terms of the command logic
  assign caps_ok      = (caps_q & ~known_flags) == '0;
  assign gen_inc      = gen_q + GEN_BITS'(1);
  assign gen_bumped   = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign succ_thr_ext = CmpW'(succ_thr_q);
  assign fail_thr_ext = CmpW'(fail_thr_q);
  assign succ_next    = ((CmpW'(succ_cnt_q) < succ_thr_ext) && (succ_cnt_q != '1))
                        ? succ_cnt_q + COUNT_BITS'(1) : succ_cnt_q;
  assign fail_next    = ((CmpW'(fail_cnt_q) < fail_thr_ext) && (fail_cnt_q != '1))
                        ? fail_cnt_q + COUNT_BITS'(1) : fail_cnt_q;

  // Apply one command to the state
  always_comb begin
    offered_d    = offered_q;
    accepted_d   = accepted_q;
    negotiated_d = negotiated_q;
    oper_d       = oper_q;
    health_d     = health_q;
    fail_cnt_d   = fail_cnt_q;
    succ_cnt_d   = succ_cnt_q;
    acc_d        = acc_q;
    gen_d        = gen_q;
    ok_d         = 1'b0;

    case (cmd_q)
      CMD_SET_OFFERED: begin
        if (caps_ok) begin
          offered_d    = caps_q;
          gen_d        = gen_bumped;
          accepted_d   = '0;
          negotiated_d = '0;
          oper_d       = '0;
          health_d     = HEALTH_UNKNOWN;
          fail_cnt_d   = '0;
          succ_cnt_d   = '0;
          acc_d        = 1'b0;
          ok_d         = 1'b1;
        end
      end
      CMD_OBSERVE: begin
        if (caps_ok && ((caps_q & ~offered_q) == '0)) begin
          ok_d = 1'b1;
          // Repeat of the same acceptance leaves everything alone
          if (!(acc_q && (accepted_q == caps_q))) begin
            accepted_d   = caps_q;
            negotiated_d = offered_q & caps_q;
            oper_d       = '0;
            health_d     = HEALTH_UNKNOWN;
            fail_cnt_d   = '0;
            succ_cnt_d   = '0;
            acc_d        = 1'b1;
            gen_d        = gen_bumped;
          end
        end
      end
      CMD_WITHDRAW: begin
        if (acc_q) begin
          gen_d = gen_bumped;
        end
        accepted_d   = '0;
        negotiated_d = '0;
        oper_d       = '0;
        health_d     = HEALTH_UNKNOWN;
        fail_cnt_d   = '0;
        succ_cnt_d   = '0;
        acc_d        = 1'b0;
        ok_d         = 1'b1;
      end
      CMD_TRANSPORT: begin
        if (acc_q) begin
          ok_d = 1'b1;
          if (success_q) begin
            fail_cnt_d = '0;
            succ_cnt_d = succ_next;
            if (CmpW'(succ_next) >= succ_thr_ext) begin
              health_d = HEALTH_HEALTHY;
              oper_d   = negotiated_q;
            end
          end else begin
            succ_cnt_d = '0;
            fail_cnt_d = fail_next;
            if (CmpW'(fail_next) >= fail_thr_ext) begin
              // Withdrawing usable capabilities invalidates leases
              if (oper_q != '0) begin
                gen_d = gen_bumped;
              end
              health_d = HEALTH_UNAVAILABLE;
              oper_d   = '0;
            end else if (health_q == HEALTH_HEALTHY || health_q == HEALTH_DEGRADED) begin
              health_d = HEALTH_DEGRADED;
              oper_d   = negotiated_q;
            end
          end
        end
      end
      CMD_CAPTURE_LEASE: begin
        ok_d = (caps_q != '0) && caps_ok && ((oper_q & caps_q) == caps_q);
      end
      CMD_CHECK_LEASE: begin
        ok_d = (lease_q != '0) && (caps_q != '0) && caps_ok &&
               (lease_q == gen_q) && ((oper_q & caps_q) == caps_q);
      end
      default: ;
    endcase
  end

  // Commit state as the request leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offered_q    <= '0;
      accepted_q   <= '0;
      negotiated_q <= '0;
      oper_q       <= '0;
      health_q     <= HEALTH_UNKNOWN;
      fail_cnt_q   <= '0;
      succ_cnt_q   <= '0;
      acc_q        <= 1'b0;
      gen_q        <= GEN_BITS'(1);
    end else if (advance) begin
      offered_q    <= offered_d;
      accepted_q   <= accepted_d;
      negotiated_q <= negotiated_d;
      oper_q       <= oper_d;
      health_q     <= health_d;
      fail_cnt_q   <= fail_cnt_d;
      succ_cnt_q   <= succ_cnt_d;
      acc_q        <= acc_d;
      gen_q        <= gen_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the ok bit with the result; state fields come from the state itself
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ok_q <= ok_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.ok               = ok_q;
  assign rsp_o.generation       = gen_q;
  assign rsp_o.health           = health_q;
  assign rsp_o.operational_caps = oper_q;
  assign rsp_o.negotiated_caps  = negotiated_q;
  assign rsp_o.acceptance_seen  = acc_q;

  // Generation skips zero
  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != '0)
    else $error("generation reached zero");

  // Usable capabilities are always negotiated ones
  a_oper_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oper_q & ~negotiated_q) == '0)
    else $error("operational set outside negotiated set");

  // Unavailable link offers nothing
  a_unav_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    health_q == HEALTH_UNAVAILABLE |-> oper_q == '0)
    else $error("operational set kept while unavailable");

  // Without acceptance the link state stays cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_q |-> (negotiated_q == '0 && health_q == HEALTH_UNKNOWN))
    else $error("link state left over without acceptance");

  // A stalled result keeps the state it reports
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> $stable(gen_q) && $stable(oper_q))
    else $error("state changed under a stalled result");

endmodule

`default_nettype wire

@@ tb/sv/tb_capability_health_tracker_core.sv @@
// Self-checking testbench of the capability health tracker core.
`timescale 1ns / 1ps

module tb_capability_health_tracker_core;
  import cht_pkg::*;

  localparam int unsigned FLAG_W       = 32;
  localparam int unsigned GEN_W        = 32;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned MAX_REPORTS  = 10;

  // Command codes the block does not define
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  // Register index the block does not define
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;

  typedef struct packed {
    logic [2:0]        command;
    logic [FLAG_W-1:0] caps;
    logic              success;
    logic [GEN_W-1:0]  lease;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [GEN_W-1:0]  gen;
    health_e           health;
    logic [FLAG_W-1:0] operational;
    logic [FLAG_W-1:0] negotiated;
    logic              seen;
  } status_t;

  typedef struct packed {
    logic [FLAG_W-1:0] offered;
    logic [FLAG_W-1:0] accepted;
    logic [FLAG_W-1:0] negotiated;
    logic [FLAG_W-1:0] operational;
    health_e           health;
    logic [CNT_W-1:0]  fails;
    logic [CNT_W-1:0]  succs;
    logic              seen;
    logic [GEN_W-1:0]  gen;
  } tracker_t;

  typedef struct packed {
    logic [KNOWN_W-1:0]  known;
    logic [THRESH_W-1:0] succ_thr;
    logic [THRESH_W-1:0] fail_thr;
  } limits_t;

  typedef struct packed {
    tracker_t st;
    status_t  rs;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cht_req_if #(.FLAG_BITS(FLAG_W), .GEN_BITS(GEN_W)) req_if ();
  cht_rsp_if #(.FLAG_BITS(FLAG_W), .GEN_BITS(GEN_W)) rsp_if ();
  cht_cfg_if cfg_if ();

  capability_health_tracker_core #(
    .FLAG_BITS  (FLAG_W),
    .GEN_BITS   (GEN_W),
    .COUNT_BITS (CNT_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Tracker copies: live follows accepted requests, plan follows queued ones
  tracker_t live_track;
  tracker_t plan_track;
  limits_t  limits;

  req_t    request_q[$];
  status_t status_q[$];

  int unsigned items_queued  = 0;
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic caps_defined(logic [FLAG_W-1:0] v, logic [KNOWN_W-1:0] known);
    return (v & ~known) == '0;
  endfunction

  // Advance the generation, skipping zero on wrap
  function automatic logic [GEN_W-1:0] next_gen(logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? {{(GEN_W-1){1'b0}}, 1'b1} : n;
  endfunction

  function automatic tracker_t clear_accept(tracker_t s);
    s.accepted    = '0;
    s.negotiated  = '0;
    s.operational = '0;
    s.health      = HEALTH_UNKNOWN;
    s.fails       = '0;
    s.succs       = '0;
    s.seen        = 1'b0;
    return s;
  endfunction

  // Apply one request to a tracker copy and report the status after it
  function automatic step_t apply_command(tracker_t s, limits_t lim, req_t rq);
    step_t r;
    logic  ok;
    logic  known_ok;
    ok       = 1'b0;
    known_ok = caps_defined(rq.caps, lim.known);
    case (rq.command)
      CMD_SET_OFFERED: begin
        if (known_ok) begin
          s.offered = rq.caps;
          s.gen     = next_gen(s.gen);
          s         = clear_accept(s);
          ok        = 1'b1;
        end
      end
      CMD_OBSERVE: begin
        if (known_ok && (rq.caps & ~s.offered) == '0) begin
          ok = 1'b1;
          // a repeated identical acceptance changes nothing
          if (!(s.seen && s.accepted == rq.caps)) begin
            s.accepted    = rq.caps;
            s.negotiated  = s.offered & rq.caps;
            s.operational = '0;
            s.health      = HEALTH_UNKNOWN;
            s.fails       = '0;
            s.succs       = '0;
            s.seen        = 1'b1;
            s.gen         = next_gen(s.gen);
          end
        end
      end
      CMD_WITHDRAW: begin
        if (s.seen) s.gen = next_gen(s.gen);
        s  = clear_accept(s);
        ok = 1'b1;
      end
      CMD_TRANSPORT: begin
        if (s.seen) begin
          ok = 1'b1;
          if (rq.success) begin
            s.fails = '0;
            if (s.succs < lim.succ_thr && s.succs != '1) s.succs = s.succs + CNT_W'(1);
            if (s.succs >= lim.succ_thr) begin
              s.health      = HEALTH_HEALTHY;
              s.operational = s.negotiated;
            end
          end else begin
            s.succs = '0;
            if (s.fails < lim.fail_thr && s.fails != '1) s.fails = s.fails + CNT_W'(1);
            if (s.fails >= lim.fail_thr) begin
              if (s.operational != '0) s.gen = next_gen(s.gen);
              s.health      = HEALTH_UNAVAILABLE;
              s.operational = '0;
            end else if (s.health == HEALTH_HEALTHY || s.health == HEALTH_DEGRADED) begin
              s.health      = HEALTH_DEGRADED;
              s.operational = s.negotiated;
            end
          end
        end
      end
      CMD_CAPTURE_LEASE: begin
        ok = rq.caps != '0 && known_ok && (s.operational & rq.caps) == rq.caps;
      end
      CMD_CHECK_LEASE: begin
        ok = rq.lease != '0 && rq.caps != '0 && known_ok && rq.lease == s.gen &&
             (s.operational & rq.caps) == rq.caps;
      end
      default: ok = 1'b0;
    endcase
    r.st             = s;
    r.rs.ok          = ok;
    r.rs.gen         = s.gen;
    r.rs.health      = s.health;
    r.rs.operational = s.operational;
    r.rs.negotiated  = s.negotiated;
    r.rs.seen        = s.seen;
    return r;
  endfunction

  // Drive requests from the pending queue; predict each one on acceptance
  always @(posedge clk_i) begin : drive_requests
    req_t  taken;
    step_t nxt;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        taken.command = req_if.command;
        taken.caps    = req_if.caps_value;
        taken.success = req_if.success;
        taken.lease   = req_if.lease_generation;
        nxt           = apply_command(live_track, limits, taken);
        live_track    = nxt.st;
        status_q.push_back(nxt.rs);
        request_q.delete(0);
      end
      // hold a stalled request, otherwise offer the next one or idle
      if (!(req_if.valid && !req_if.ready)) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid            <= 1'b1;
          req_if.command          <= request_q[0].command;
          req_if.caps_value       <= request_q[0].caps;
          req_if.success          <= request_q[0].success;
          req_if.lease_generation <= request_q[0].lease;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_request != hold_served) begin
      hold_left   <= LONG_HOLD;
      hold_served <= hold_request;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Compare each result with the oldest prediction; stall at random
  always @(posedge clk_i) begin : check_results
    status_t want;
    status_t got;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.ok          = rsp_if.ok;
        got.gen         = rsp_if.generation;
        got.health      = health_e'(rsp_if.health);
        got.operational = rsp_if.operational_caps;
        got.negotiated  = rsp_if.negotiated_caps;
        got.seen        = rsp_if.acceptance_seen;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with no request outstanding: ok=%0d gen=%h health=%0d",
                     $time, got.ok, got.gen, got.health);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: want ok=%0d gen=%h health=%0d op=%h neg=%h seen=%0d",
                       $time, want.ok, want.gen, want.health, want.operational,
                       want.negotiated, want.seen);
              $display("%0t:  got ok=%0d gen=%h health=%0d op=%h neg=%h seen=%0d",
                       $time, got.ok, got.gen, got.health, got.operational,
                       got.negotiated, got.seen);
            end
          end
        end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void queue_request(logic [2:0] cmd, logic [FLAG_W-1:0] caps,
                                        logic succ, logic [GEN_W-1:0] lease);
    req_t  rq;
    step_t p;
    rq.command = cmd;
    rq.caps    = caps;
    rq.success = succ;
    rq.lease   = lease;
    request_q.push_back(rq);
    p          = apply_command(plan_track, limits, rq);
    plan_track = p.st;
    items_queued++;
  endfunction

  function automatic logic [FLAG_W-1:0] pick_caps();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom & limits.known;
      2:       return 32'h1 << $urandom_range(FLAG_W - 1);
      3:       return '1;
      4:       return '0;
      default: return $urandom & $urandom & limits.known;
    endcase
  endfunction

  // Mostly a subset of the usable set, sometimes anything
  function automatic logic [FLAG_W-1:0] lease_caps();
    logic [FLAG_W-1:0] sub;
    sub = plan_track.operational & $urandom;
    if (sub == '0) sub = plan_track.operational;
    return ($urandom_range(4) == 0) ? pick_caps() : sub;
  endfunction

  // Queue one offer/accept session followed by traffic and lease use
  task automatic queue_session();
    logic [FLAG_W-1:0] offered;
    logic [FLAG_W-1:0] accepted;
    logic [GEN_W-1:0]  lease;
    int unsigned       sel;
    int unsigned       len;
    bit                good;
    offered = ($urandom_range(9) == 0) ? pick_caps() : ($urandom & limits.known);
    queue_request(CMD_SET_OFFERED, offered, 1'($urandom_range(1)), $urandom);
    accepted = ($urandom_range(7) == 0) ? pick_caps() : (offered & $urandom);
    if (accepted == '0 && $urandom_range(3) != 0) accepted = offered;
    queue_request(CMD_OBSERVE, accepted, 1'($urandom_range(1)), $urandom);
    repeat ($urandom_range(4, 12)) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        // a run of transport results, mostly of one outcome
        len  = $urandom_range(1, 17);
        good = 1'($urandom_range(1));
        repeat (len)
          queue_request(CMD_TRANSPORT, $urandom, good ^ ($urandom_range(7) == 0), $urandom);
      end else if (sel < 62) begin
        queue_request(CMD_CAPTURE_LEASE, lease_caps(), 1'($urandom_range(1)), $urandom);
      end else if (sel < 80) begin
        case ($urandom_range(5))
          0:       lease = plan_track.gen - GEN_W'(1);
          1:       lease = '0;
          2:       lease = $urandom;
          default: lease = plan_track.gen;
        endcase
        queue_request(CMD_CHECK_LEASE, lease_caps(), 1'($urandom_range(1)), lease);
      end else if (sel < 87) begin
        if ($urandom_range(1) != 0) accepted = offered & $urandom;
        queue_request(CMD_OBSERVE, accepted, 1'($urandom_range(1)), $urandom);
      end else if (sel < 92) begin
        queue_request(CMD_WITHDRAW, $urandom, 1'($urandom_range(1)), $urandom);
      end else if (sel < 95) begin
        queue_request(($urandom_range(1) != 0) ? CMD_RSVD_A : CMD_RSVD_B, $urandom,
                      1'($urandom_range(1)), $urandom);
      end else begin
        offered = pick_caps();
        queue_request(CMD_SET_OFFERED, offered, 1'($urandom_range(1)), $urandom);
      end
    end
  endtask

  task automatic run_sessions(int unsigned count);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < count) queue_session();
  endtask

  // Wait until every request is accepted and every result has come back
  task automatic wait_idle();
    while (request_q.size() != 0 || status_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_pace(int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    stall_pct     = stall;
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_KNOWN_MASK:   limits.known    = val[KNOWN_W-1:0];
      REG_SUCC_TO_OK:   limits.succ_thr = val[THRESH_W-1:0];
      REG_FAIL_TO_UNAV: limits.fail_thr = val[THRESH_W-1:0];
      default:          ;
    endcase
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_limits(logic [KNOWN_W-1:0] known, logic [THRESH_W-1:0] succ,
                            logic [THRESH_W-1:0] fail);
    wait_idle();
    write_limit(REG_KNOWN_MASK, known);
    write_limit(REG_SUCC_TO_OK, {{(CFG_DATA_W-THRESH_W){1'b0}}, succ});
    write_limit(REG_FAIL_TO_UNAV, {{(CFG_DATA_W-THRESH_W){1'b0}}, fail});
  endtask

  initial begin : stimulus
    int unsigned rand_start;
    rst_ni                  = 1'b0;
    req_if.valid            = 1'b0;
    req_if.command          = CMD_SET_OFFERED;
    req_if.caps_value       = '0;
    req_if.success          = 1'b0;
    req_if.lease_generation = '0;
    rsp_if.ready            = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = REG_KNOWN_MASK;
    cfg_if.data             = '0;
    live_track              = '0;
    live_track.gen          = {{(GEN_W-1){1'b0}}, 1'b1};
    plan_track              = live_track;
    limits.known            = KNOWN_MASK_RST;
    limits.succ_thr         = SUCC_THR_RST;
    limits.fail_thr         = FAIL_THR_RST;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed walk through the commands at the reset register values
    set_pace(0, 0);
    queue_request(CMD_CHECK_LEASE, 32'h1, 1'b0, 32'h1);
    queue_request(CMD_TRANSPORT, '0, 1'b1, '0);
    queue_request(CMD_WITHDRAW, '0, 1'b0, '0);
    queue_request(CMD_RSVD_A, '1, 1'b1, '1);
    queue_request(CMD_RSVD_B, '1, 1'b0, '1);
    queue_request(CMD_SET_OFFERED, '1, 1'b0, '0);
    queue_request(CMD_OBSERVE, 32'h0000_00f0, 1'b0, '0);
    queue_request(CMD_OBSERVE, 32'h0000_00f0, 1'b0, '0);
    repeat (3) queue_request(CMD_TRANSPORT, '1, 1'b1, '1);
    queue_request(CMD_CAPTURE_LEASE, 32'h0000_00f0, 1'b0, '0);
    queue_request(CMD_CAPTURE_LEASE, '0, 1'b0, '0);
    queue_request(CMD_CAPTURE_LEASE, 32'h0000_0001, 1'b0, '0);
    queue_request(CMD_CHECK_LEASE, 32'h0000_0030, 1'b0, plan_track.gen);
    queue_request(CMD_CHECK_LEASE, 32'h0000_0030, 1'b0, plan_track.gen - GEN_W'(1));
    queue_request(CMD_CHECK_LEASE, 32'h0000_0030, 1'b0, '0);
    queue_request(CMD_CHECK_LEASE, 32'h0000_0030, 1'b0, '1);
    repeat (4) queue_request(CMD_TRANSPORT, '0, 1'b0, '0);
    queue_request(CMD_SET_OFFERED, 32'h0000_00ff, 1'b1, '1);
    queue_request(CMD_OBSERVE, 32'h0000_0100, 1'b0, '0);
    queue_request(CMD_OBSERVE, 32'h0000_0081, 1'b0, '0);
    queue_request(CMD_WITHDRAW, '1, 1'b1, '1);
    rand_start = items_queued;

    // Lowest thresholds, no idling
    set_limits('1, 4'd1, 4'd1);
    run_sessions(50);

    // Highest thresholds, narrow mask, sender idling
    set_limits(32'h0000_ffff, 4'd15, 4'd15);
    set_pace(49, 0);
    queue_request(CMD_SET_OFFERED, 32'h0001_0000, 1'b0, '0);
    queue_request(CMD_CHECK_LEASE, 32'h8000_0000, 1'b0, plan_track.gen);
    run_sessions(60);

    // Zero thresholds, receiver stalling
    set_limits('1, 4'd0, 4'd0);
    set_pace(0, 49);
    run_sessions(25);

    // No defined capability bits; an undefined index is ignored
    set_limits('0, 4'd2, 4'd3);
    write_limit(REG_SPARE, '1);
    run_sessions(15);

    // Random register values, both sides idling
    set_limits($urandom, THRESH_W'($urandom_range(1, 15)), THRESH_W'($urandom_range(1, 15)));
    set_pace(34, 34);
    run_sessions(60);

    // Back-pressure: receiver holds off while the sender keeps offering
    set_limits(KNOWN_MASK_RST, SUCC_THR_RST, FAIL_THR_RST);
    set_pace(0, 0);
    run_sessions(40);
    hold_request++;
    wait_idle();

    // Fill up the rest with random registers, receiver stalling
    set_limits($urandom | 32'hff00_0000, THRESH_W'($urandom_range(1, 15)),
               THRESH_W'($urandom_range(1, 15)));
    set_pace(0, 49);
    while (items_queued - rand_start < RANDOM_ITEMS) queue_session();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("capability_health_tracker_core: match");
    end else begin
      $display("capability_health_tracker_core: mismatch");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #4000000;
    $display("capability_health_tracker_core: mismatch");
    $finish;
  end

endmodule
